@@ rtl/tcw_pkg.sv @@
// shared constants, codes and types of the text console writer
package tcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int KEEP    = COLUMNS * (ROWS - 1);

  localparam int CELL_AW = $clog2(CELLS);
  localparam int COL_W   = $clog2(COLUMNS);
  localparam int ROW_W   = $clog2(ROWS);

  localparam int OP_W   = 2;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int IDX_W  = 11;
  localparam int POS_W  = 11;
  localparam int CELL_W = CHAR_W + ATTR_W;

  localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0]  NUL_CODE     = 8'd0;
  localparam logic [ATTR_W-1:0]  FILL_RESET   = 8'd15;

  localparam logic [CELL_AW-1:0] LAST_CELL = CELL_AW'(CELLS - 1);
  localparam logic [CELL_AW-1:0] KEEP_ADDR = CELL_AW'(KEEP);
  localparam logic [CELL_AW-1:0] COLS_ADDR = CELL_AW'(COLUMNS);
  localparam logic [COL_W-1:0]   LAST_COL  = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0]   LAST_ROW  = ROW_W'(ROWS - 1);
  localparam logic [IDX_W-1:0]   CELLS_IDX = IDX_W'(CELLS);

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [8:0] {
    ST_INIT    = 9'b000000001,
    ST_IDLE    = 9'b000000010,
    ST_WR      = 9'b000000100,
    ST_RDNEXT  = 9'b000001000,
    ST_FIXATTR = 9'b000010000,
    ST_SCROLL  = 9'b000100000,
    ST_FILL    = 9'b001000000,
    ST_RDCELL  = 9'b010000000,
    ST_DONE    = 9'b100000000
  } state_t;

  typedef struct packed {
    logic               we;
    logic [CELL_AW-1:0] waddr;
    logic [CHAR_W-1:0]  wchar;
    logic [ATTR_W-1:0]  wattr;
    logic               re;
    logic [CELL_AW-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [POS_W-1:0]  cursor;
    logic [CHAR_W-1:0] rd_char;
    logic [ATTR_W-1:0] rd_attr;
    logic              scrolled;
  } result_t;

endpackage

@@ rtl/tcw_if.sv @@
// handshake channel interfaces for operations and results
interface tcw_in_if import tcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [CHAR_W-1:0] char_code;
  logic [ATTR_W-1:0] char_colour;
  logic [IDX_W-1:0]  cell_index;

  modport source (output valid, opcode, char_code, char_colour, cell_index, input ready);
  modport sink   (input valid, opcode, char_code, char_colour, cell_index, output ready);
endinterface

interface tcw_out_if import tcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [POS_W-1:0]  cursor_position;
  logic [CHAR_W-1:0] cell_char;
  logic [ATTR_W-1:0] cell_attr;
  logic              did_scroll;

  modport source (output valid, cursor_position, cell_char, cell_attr, did_scroll, input ready);
  modport sink   (input valid, cursor_position, cell_char, cell_attr, did_scroll, output ready);
endinterface

@@ rtl/tcw_ram.sv @@
// screen cell buffer, one write and one registered read port
module tcw_ram import tcw_pkg::*; (
  input  logic              clk,
  input  mem_req_t          mem_req,
  output logic [CELL_W-1:0] rdata
);

  logic [CELL_W-1:0] mem [CELLS];

  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      mem[mem_req.waddr] <= {mem_req.wchar, mem_req.wattr};
    end
    if (mem_req.re) begin
      rdata <= mem[mem_req.raddr];
    end
  end

endmodule

@@ rtl/tcw_ctrl.sv @@
// sequencer: cursor tracking, cell writes and reads, scroll copy and fill sweeps
module tcw_ctrl import tcw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OP_W-1:0]   in_opcode,
  input  logic [CHAR_W-1:0] in_char_code,
  input  logic [ATTR_W-1:0] in_char_colour,
  input  logic [IDX_W-1:0]  in_cell_index,
  input  logic [ATTR_W-1:0] fill_colour,
  output mem_req_t          mem_req,
  input  logic [CELL_W-1:0] mem_rdata,
  output logic              res_valid,
  input  logic              res_ready,
  output result_t           res
);

  state_t             state_r, state_nxt;
  logic [CELL_AW-1:0] cnt_r, cnt_nxt;
  logic [CELL_AW-1:0] cursor_r, cursor_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic               pend_r, pend_nxt;
  logic [CELL_AW-1:0] dst_r, dst_nxt;
  logic               scrolled_r, scrolled_nxt;
  logic [CHAR_W-1:0]  char_r, char_nxt;
  logic [ATTR_W-1:0]  colour_r, colour_nxt;
  logic [CHAR_W-1:0]  rd_char_r, rd_char_nxt;
  logic [ATTR_W-1:0]  rd_attr_r, rd_attr_nxt;

  logic [CELL_AW-1:0] alu_a, alu_b, alu_sum;
  logic [CELL_AW-1:0] cnt_inc;
  logic               accept, nl, wrap_col, last_cell;

  assign alu_sum   = alu_a + alu_b;
  assign cnt_inc   = cnt_r + CELL_AW'(1);
  assign accept    = in_valid && (state_r == ST_IDLE);
  assign in_ready  = (state_r == ST_IDLE);
  assign nl        = (char_r == NEWLINE_CODE);
  assign wrap_col  = nl || (col_r == LAST_COL);
  assign last_cell = (row_r == LAST_ROW) && wrap_col;

  assign res_valid    = (state_r == ST_DONE);
  assign res.cursor   = POS_W'(cursor_r);
  assign res.rd_char  = rd_char_r;
  assign res.rd_attr  = rd_attr_r;
  assign res.scrolled = scrolled_r;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    cursor_nxt   = cursor_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    pend_nxt     = pend_r;
    dst_nxt      = dst_r;
    scrolled_nxt = scrolled_r;
    char_nxt     = char_r;
    colour_nxt   = colour_r;
    rd_char_nxt  = rd_char_r;
    rd_attr_nxt  = rd_attr_r;
    alu_a        = cursor_r;
    alu_b        = CELL_AW'(1);
    mem_req      = '0;

    unique case (state_r)
      ST_INIT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = cnt_r;
        if (cnt_r == LAST_CELL) begin
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_inc;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          char_nxt     = in_char_code;
          colour_nxt   = in_char_colour;
          scrolled_nxt = 1'b0;
          rd_char_nxt  = '0;
          rd_attr_nxt  = '0;
          unique case (op_t'(in_opcode))
            OP_WRITE: state_nxt = ST_WR;
            OP_CLEAR: begin
              cnt_nxt   = '0;
              state_nxt = ST_FILL;
            end
            OP_READ: begin
              if (in_cell_index < CELLS_IDX) begin
                mem_req.re    = 1'b1;
                mem_req.raddr = in_cell_index[CELL_AW-1:0];
                state_nxt     = ST_RDCELL;
              end else begin
                state_nxt = ST_DONE;
              end
            end
            OP_NONE: state_nxt = ST_DONE;
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_WR: begin
        alu_a = cursor_r;
        alu_b = nl ? (COLS_ADDR - CELL_AW'(col_r)) : CELL_AW'(1);
        if (!nl) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = cursor_r;
          mem_req.wchar = char_r;
          mem_req.wattr = colour_r;
        end
        if (last_cell) begin
          scrolled_nxt = 1'b1;
          cnt_nxt      = '0;
          pend_nxt     = 1'b0;
          state_nxt    = ST_SCROLL;
        end else begin
          cursor_nxt = alu_sum;
          if (wrap_col) begin
            col_nxt = '0;
            row_nxt = row_r + ROW_W'(1);
          end else begin
            col_nxt = col_r + COL_W'(1);
          end
          state_nxt = ST_RDNEXT;
        end
      end
      ST_RDNEXT: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = cursor_r;
        state_nxt     = ST_FIXATTR;
      end
      ST_FIXATTR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = cursor_r;
        mem_req.wchar = mem_rdata[CELL_W-1:ATTR_W];
        mem_req.wattr = fill_colour;
        state_nxt     = ST_DONE;
      end
      ST_SCROLL: begin
        // read one row below while writing back the cell fetched last cycle
        alu_a         = cnt_r;
        alu_b         = COLS_ADDR;
        mem_req.re    = (cnt_r != KEEP_ADDR);
        mem_req.raddr = alu_sum;
        mem_req.we    = pend_r;
        mem_req.waddr = dst_r;
        mem_req.wchar = mem_rdata[CELL_W-1:ATTR_W];
        mem_req.wattr = mem_rdata[ATTR_W-1:0];
        pend_nxt      = (cnt_r != KEEP_ADDR);
        dst_nxt       = cnt_r;
        if (cnt_r == KEEP_ADDR) begin
          state_nxt = ST_FILL;
        end else begin
          cnt_nxt = cnt_inc;
        end
      end
      ST_FILL: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = cnt_r;
        mem_req.wchar = NUL_CODE;
        mem_req.wattr = fill_colour;
        if (cnt_r == LAST_CELL) begin
          cursor_nxt = scrolled_r ? KEEP_ADDR : '0;
          col_nxt    = '0;
          row_nxt    = scrolled_r ? LAST_ROW : '0;
          state_nxt  = ST_DONE;
        end else begin
          cnt_nxt = cnt_inc;
        end
      end
      ST_RDCELL: begin
        rd_char_nxt = mem_rdata[CELL_W-1:ATTR_W];
        rd_attr_nxt = mem_rdata[ATTR_W-1:0];
        state_nxt   = ST_DONE;
      end
      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_INIT;
      cnt_r      <= '0;
      cursor_r   <= '0;
      col_r      <= '0;
      row_r      <= '0;
      pend_r     <= 1'b0;
      scrolled_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      cursor_r   <= cursor_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      pend_r     <= pend_nxt;
      scrolled_r <= scrolled_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dst_r     <= dst_nxt;
    char_r    <= char_nxt;
    colour_r  <= colour_nxt;
    rd_char_r <= rd_char_nxt;
    rd_attr_r <= rd_attr_nxt;
  end

endmodule

@@ rtl/text_console_writer_core.sv @@
// text console writer top level: config register, sequencer, cell buffer, result register
//
//   channel   dir  handshake          payload
//   in_ch     in   valid/ready        opcode, char_code, char_colour, cell_index
//   out_ch    out  valid/ready        cursor_position, cell_char, cell_attr, did_scroll
//   cfg_*     in   cfg_we             cfg_wdata (fill colour)
//
// a scroll copies each cell up a row, one cell per cycle through the ram port pair, then fills the bottom row
// a clear fills every cell, one cell write per cycle
// after reset the buffer is zeroed with in_ch.ready low
// one result register: the next transaction is taken while a result waits on out_ch
module text_console_writer_core import tcw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  tcw_in_if.sink            in_ch,
  tcw_out_if.source         out_ch,
  input  logic              cfg_we,
  input  logic [ATTR_W-1:0] cfg_wdata
);

  logic [ATTR_W-1:0] fill_colour_r;
  logic              out_valid_r;
  result_t           out_res_r;
  mem_req_t          mem_req;
  logic [CELL_W-1:0] mem_rdata;
  logic              res_valid, res_ready;
  result_t           res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_colour_r <= FILL_RESET;
    end else if (cfg_we) begin
      fill_colour_r <= cfg_wdata;
    end
  end

  tcw_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_opcode      (in_ch.opcode),
    .in_char_code   (in_ch.char_code),
    .in_char_colour (in_ch.char_colour),
    .in_cell_index  (in_ch.cell_index),
    .fill_colour    (fill_colour_r),
    .mem_req        (mem_req),
    .mem_rdata      (mem_rdata),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .res            (res)
  );

  tcw_ram u_ram (
    .clk     (clk),
    .mem_req (mem_req),
    .rdata   (mem_rdata)
  );

  assign res_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.cursor_position = out_res_r.cursor;
  assign out_ch.cell_char       = out_res_r.rd_char;
  assign out_ch.cell_attr       = out_res_r.rd_attr;
  assign out_ch.did_scroll      = out_res_r.scrolled;

`ifndef NO_ASSERTIONS
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.cursor_position < POS_W'(CELLS)))
    else $error("cursor beyond the screen");

  a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.did_scroll) |-> (out_ch.cursor_position == POS_W'(KEEP)))
    else $error("scroll left cursor off the bottom row start");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("second transaction taken while busy");
`endif

endmodule

@@ bench/tb_text_console_writer_core.sv @@
// self-checking testbench for the text console writer: directed, pressure and random traffic
module tb_text_console_writer_core;
  import tcw_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 8_000_000;
  localparam int unsigned TAIL_CYCLES  = CELLS + 100;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [ATTR_W-1:0] cfg_wdata;

  tcw_in_if  in_ch ();
  tcw_out_if out_ch ();

  text_console_writer_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // screen image kept alongside the block
  logic [CHAR_W-1:0] screen_char [CELLS];
  logic [ATTR_W-1:0] screen_attr [CELLS];
  int unsigned       cursor_at;
  logic [ATTR_W-1:0] fill_attr;

  result_t     expected_results [$];
  int unsigned cycle_count;
  int unsigned mismatch_count;
  int unsigned results_checked;
  int unsigned writes_sent, reads_sent, clears_sent, unused_sent, scrolls_seen, fill_writes;
  bit          tx_gaps;
  bit          rx_gaps;
  bit          offering;
  int unsigned hold_request;
  int unsigned hold_left;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic result_t console_apply(op_t op, logic [CHAR_W-1:0] ch,
                                            logic [ATTR_W-1:0] colour,
                                            logic [IDX_W-1:0] idx);
    result_t     r;
    int unsigned pos;
    r = '0;
    case (op)
      OP_WRITE: begin
        writes_sent++;
        pos = (cursor_at >= CELLS) ? 0 : cursor_at;
        if (ch == NEWLINE_CODE) begin
          pos = (pos / COLUMNS + 1) * COLUMNS;
        end else begin
          screen_char[pos] = ch;
          screen_attr[pos] = colour;
          pos++;
        end
        if (pos >= CELLS) begin
          for (int i = 0; i < KEEP; i++) begin
            screen_char[i] = screen_char[i + COLUMNS];
            screen_attr[i] = screen_attr[i + COLUMNS];
          end
          for (int i = KEEP; i < CELLS; i++) begin
            screen_char[i] = NUL_CODE;
            screen_attr[i] = fill_attr;
          end
          r.scrolled = 1'b1;
          scrolls_seen++;
          pos = KEEP;
        end
        cursor_at = pos;
        screen_attr[pos] = fill_attr;
      end
      OP_CLEAR: begin
        clears_sent++;
        for (int i = 0; i < CELLS; i++) begin
          screen_char[i] = NUL_CODE;
          screen_attr[i] = fill_attr;
        end
        cursor_at = 0;
        screen_attr[0] = fill_attr;
      end
      OP_READ: begin
        reads_sent++;
        if (idx < CELLS) begin
          r.rd_char = screen_char[idx];
          r.rd_attr = screen_attr[idx];
        end
      end
      default: unused_sent++;
    endcase
    r.cursor = POS_W'(cursor_at);
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    mismatch_count++;
    if (mismatch_count <= 30)
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
  endtask

  task automatic send_op(op_t op, logic [CHAR_W-1:0] ch, logic [ATTR_W-1:0] colour,
                         logic [IDX_W-1:0] idx);
    result_t r;
    if (tx_gaps && $urandom_range(99) < 20) begin
      if (offering) begin
        in_ch.valid <= 1'b0;
        offering = 1'b0;
      end
      do @(negedge clk); while ($urandom_range(99) < 20);
    end
    in_ch.valid       <= 1'b1;
    offering           = 1'b1;
    in_ch.opcode      <= op;
    in_ch.char_code   <= ch;
    in_ch.char_colour <= colour;
    in_ch.cell_index  <= idx;
    do @(posedge clk); while (!in_ch.ready);
    r = console_apply(op, ch, colour, idx);
    expected_results.push_back(r);
    @(negedge clk);
  endtask

  task automatic send_write(logic [CHAR_W-1:0] ch, logic [ATTR_W-1:0] colour);
    send_op(OP_WRITE, ch, colour, IDX_W'($urandom_range(0, 2047)));
  endtask

  task automatic send_read(logic [IDX_W-1:0] idx);
    send_op(OP_READ, CHAR_W'($urandom_range(0, 255)), ATTR_W'($urandom_range(0, 255)), idx);
  endtask

  task automatic send_clear();
    send_op(OP_CLEAR, CHAR_W'($urandom_range(0, 255)), ATTR_W'($urandom_range(0, 255)),
            IDX_W'($urandom_range(0, 2047)));
  endtask

  task automatic pause_until_drained();
    if (offering) begin
      in_ch.valid <= 1'b0;
      offering = 1'b0;
    end
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  task automatic set_fill(logic [ATTR_W-1:0] value);
    pause_until_drained();
    repeat (4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    fill_attr  = value;
    fill_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_random_traffic(int unsigned n_items);
    int unsigned sent;
    int unsigned kind;
    int unsigned len;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(99);
      if (kind < 40) begin
        len = $urandom_range(1, 24);
        repeat (len) send_write(CHAR_W'($urandom_range(0, 255)), ATTR_W'($urandom_range(0, 255)));
      end else if (kind < 60) begin
        len = $urandom_range(1, 8);
        repeat (len) send_write(NEWLINE_CODE, ATTR_W'($urandom_range(0, 255)));
      end else if (kind < 78) begin
        len = $urandom_range(1, 4);
        repeat (len) begin
          case ($urandom_range(0, 2))
            0: send_read(IDX_W'(cursor_at + $urandom_range(0, 3) - 1));
            1: send_read(IDX_W'($urandom_range(0, CELLS - 1)));
            default: send_read(IDX_W'($urandom_range(0, 2047)));
          endcase
        end
      end else if (kind < 83) begin
        len = 1;
        send_clear();
      end else if (kind < 90) begin
        len = 0;
        send_op(OP_NONE, CHAR_W'($urandom_range(0, 255)), ATTR_W'($urandom_range(0, 255)),
                IDX_W'($urandom_range(0, 2047)));
      end else begin
        len = $urandom_range(30, 85);
        repeat (len) send_write(CHAR_W'($urandom_range(11, 255)), ATTR_W'($urandom_range(0, 255)));
      end
      sent += len;
    end
  endtask

  task automatic test_reset_reads();
    send_read(IDX_W'(0));
    send_read(IDX_W'(CELLS - 1));
    send_read(CELLS_IDX);
    send_read('1);
    send_op(OP_NONE, '1, '1, '1);
  endtask

  task automatic test_basic_ops();
    send_write(8'h00, 8'h00);
    send_write(8'hFF, 8'hFF);
    send_write(8'h41, 8'hAA);
    send_write(NEWLINE_CODE, 8'h55);
    send_read(IDX_W'(0));
    send_read(IDX_W'(1));
    send_read(IDX_W'(2));
    send_read(IDX_W'(3));
    send_read(IDX_W'(COLUMNS));
    send_op(OP_NONE, 8'h00, 8'h00, '0);
    send_clear();
    send_read(IDX_W'(0));
    send_read(IDX_W'(1));
    send_read(IDX_W'(CELLS - 1));
    send_write(8'h7E, 8'h3C);
  endtask

  task automatic test_scroll_edges();
    set_fill(8'h00);
    send_clear();
    repeat (ROWS - 1) send_write(NEWLINE_CODE, 8'h12);
    // newline on the bottom row
    send_write(NEWLINE_CODE, 8'h34);
    repeat (COLUMNS - 1) send_write(CHAR_W'($urandom_range(11, 255)), ATTR_W'($urandom_range(0, 255)));
    // write into the last cell, pushing the cursor past the end
    send_write(8'h5A, 8'hC3);
    send_read(IDX_W'(KEEP - COLUMNS));
    send_read(IDX_W'(KEEP - 1));
    send_read(IDX_W'(KEEP));
    send_read(IDX_W'(CELLS - 1));
  endtask

  task automatic test_fill_max();
    set_fill(8'hFF);
    send_clear();
    send_read(IDX_W'(1500));
    send_write(8'h20, 8'h01);
    send_read(IDX_W'(0));
    send_read(IDX_W'(1));
    set_fill(FILL_RESET);
    send_write(NEWLINE_CODE, 8'h00);
    send_read(IDX_W'(COLUMNS));
  endtask

  task automatic test_backpressure();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    hold_request = 400;
    repeat (10) send_write(CHAR_W'($urandom_range(11, 255)), ATTR_W'($urandom_range(0, 255)));
    send_read(IDX_W'(cursor_at - 1));
    pause_until_drained();
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
  endtask

  task automatic test_no_idle();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    send_random_traffic(80);
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
  endtask

  task automatic test_random_traffic();
    for (int chunk = 0; chunk < 5; chunk++) begin
      case (chunk)
        0: set_fill(8'h00);
        1: set_fill(8'hFF);
        default: set_fill(ATTR_W'($urandom_range(0, 255)));
      endcase
      send_random_traffic(65);
    end
  endtask

  // result sink with random stalls and long hold-offs
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !(rx_gaps && $urandom_range(99) < 20);
      end
    end
  end

  always @(posedge clk) begin : check_results
    result_t want;
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_text_console_writer_core: FAIL");
      $finish;
    end else if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("transaction with nothing expected, cursor", out_ch.cursor_position, 0);
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (out_ch.cursor_position !== want.cursor)
          report_mismatch("cursor_position", out_ch.cursor_position, want.cursor);
        if (out_ch.cell_char !== want.rd_char)
          report_mismatch("cell_char", out_ch.cell_char, want.rd_char);
        if (out_ch.cell_attr !== want.rd_attr)
          report_mismatch("cell_attr", out_ch.cell_attr, want.rd_attr);
        if (out_ch.did_scroll !== want.scrolled)
          report_mismatch("did_scroll", out_ch.did_scroll, want.scrolled);
      end
    end
  end

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.opcode      = '0;
    in_ch.char_code   = '0;
    in_ch.char_colour = '0;
    in_ch.cell_index  = '0;
    offering          = 1'b0;
    tx_gaps           = 1'b1;
    rx_gaps           = 1'b1;
    hold_request      = 0;
    hold_left         = 0;
    cursor_at         = 0;
    fill_attr         = FILL_RESET;
    for (int i = 0; i < CELLS; i++) begin
      screen_char[i] = '0;
      screen_attr[i] = '0;
    end
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_reads();
    test_basic_ops();
    test_scroll_edges();
    test_fill_max();
    test_backpressure();
    test_no_idle();
    test_random_traffic();

    pause_until_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    $display("summary: %0d writes, %0d reads, %0d clears, %0d unused opcodes, %0d results checked",
             writes_sent, reads_sent, clears_sent, unused_sent, results_checked);
    $display("summary: %0d scrolls, %0d fill colour settings, %0d mismatches",
             scrolls_seen, fill_writes, mismatch_count);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("tb_text_console_writer_core: PASS");
    end else begin
      $display("tb_text_console_writer_core: FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/tcw_pkg.sv
rtl/tcw_if.sv
rtl/tcw_ram.sv
rtl/tcw_ctrl.sv
rtl/text_console_writer_core.sv
bench/tb_text_console_writer_core.sv
